### src/ssmm_pkg.sv
package ssmm_pkg;

  localparam int MAX_ELEMS   = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int TARGET_W    = 21;
  localparam int IDX_W       = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ELEMS + 1);
  localparam int SUM_W       = (VALUE_WIDTH + CNT_W > TARGET_W) ?
                               (VALUE_WIDTH + CNT_W) : TARGET_W;

  // microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] U_INIT = 4'd1;
  localparam logic [UPC_W-1:0] U_EXAM = 4'd2;
  localparam logic [UPC_W-1:0] U_ADV  = 4'd3;
  localparam logic [UPC_W-1:0] U_ACC  = 4'd4;
  localparam logic [UPC_W-1:0] U_EBEG = 4'd5;
  localparam logic [UPC_W-1:0] U_RD   = 4'd6;
  localparam logic [UPC_W-1:0] U_OUT  = 4'd7;
  localparam logic [UPC_W-1:0] U_NSET = 4'd8;
  localparam logic [UPC_W-1:0] U_DONE = 4'd9;
  localparam logic [UPC_W-1:0] U_MARK = 4'd10;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] C_WAIT   = 3'd2;
  localparam logic [COND_W-1:0] C_DONE   = 3'd3;
  localparam logic [COND_W-1:0] C_EMPTY  = 3'd4;
  localparam logic [COND_W-1:0] C_MORE   = 3'd5;
  localparam logic [COND_W-1:0] C_FIRST  = 3'd6;

  typedef struct packed {
    logic              clr_search;
    logic              exam;
    logic              advance;
    logic              accum;
    logic              emit_begin;
    logic              rd_elem;
    logic              emit_member;
    logic              emit_marker;
    logic              next_set;
    logic              finish;
    logic [COND_W-1:0] cond_sel;
    logic [UPC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic wait_go;
    logic search_done;
    logic mask_empty;
    logic scan_more;
    logic first_set;
  } ucond_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    unique case (addr)
      U_IDLE: begin
        w.cond_sel = C_WAIT;
        w.target   = U_IDLE;
      end
      U_INIT: w.clr_search = 1'b1;
      U_EXAM: begin
        w.exam     = 1'b1;
        w.cond_sel = C_DONE;
        w.target   = U_EBEG;
      end
      U_ADV: w.advance = 1'b1;
      U_ACC: begin
        w.accum    = 1'b1;
        w.cond_sel = C_ALWAYS;
        w.target   = U_EXAM;
      end
      U_EBEG: begin
        w.emit_begin = 1'b1;
        w.cond_sel   = C_EMPTY;
        w.target     = U_MARK;
      end
      U_RD: w.rd_elem = 1'b1;
      U_OUT: begin
        w.emit_member = 1'b1;
        w.cond_sel    = C_MORE;
        w.target      = U_RD;
      end
      U_NSET: begin
        w.next_set = 1'b1;
        w.cond_sel = C_FIRST;
        w.target   = U_EBEG;
      end
      U_DONE: begin
        w.finish   = 1'b1;
        w.cond_sel = C_ALWAYS;
        w.target   = U_IDLE;
      end
      U_MARK: begin
        w.emit_marker = 1'b1;
        w.cond_sel    = C_ALWAYS;
        w.target      = U_NSET;
      end
      default: begin
        w.cond_sel = C_ALWAYS;
        w.target   = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // index of the lowest set bit
  function automatic logic [IDX_W-1:0] ctz(input logic [MAX_ELEMS-1:0] v);
    logic [IDX_W-1:0] r;
    logic             hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if (!hit && v[i]) begin
        r   = IDX_W'(i);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [MAX_ELEMS-1:0] bitrev(input logic [MAX_ELEMS-1:0] v);
    logic [MAX_ELEMS-1:0] r;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      r[MAX_ELEMS-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

### src/subset_sum_min_max_cardinality.sv
// subset-sum search keeping the largest and smallest matching subsets
//
// input requests: element_value / last_element are taken at a rising edge with
// start high and busy low. requests without last_element only load the element
// store (one per cycle, extra elements beyond the store depth are dropped).
// a request with last_element starts the search over all 2^n subsets of the
// n loaded elements; busy stays high until the whole answer is out.
// config: target_sum is written over cfg_valid / cfg_ready / cfg_data while idle
// results: flagged by result_valid for a single cycle; the receiver cannot
// stall. members of the largest subset come first (which_subset 0), then
// the smallest (which_subset 1), in index order; an empty or missing subset
// gives one marker with is_member low. last_result marks the final result
// of the run.
// search: the search walks the subsets in gray-code order, one element add or
// subtract per step; each subset costs three microcode steps (examine,
// advance, accumulate). the answer scan of a non-empty list takes two steps
// per element.
// reset: clears the element count, the stored answer and target_sum; no
// result is pending after reset.
module subset_sum_min_max_cardinality import ssmm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] element_value,
  input  logic                          last_element,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic signed [TARGET_W-1:0]    cfg_data,
  output logic                          result_valid,
  output logic                          which_subset,
  output logic signed [VALUE_WIDTH-1:0] member_value,
  output logic                          is_member,
  output logic                          found,
  output logic                          last_result
);

  uword_t ctrl;
  ucond_t cond;

  // element store and load side
  logic signed [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMS];
  logic [CNT_W-1:0]              count;
  logic signed [TARGET_W-1:0]    target_sum;
  logic                          accept;

  // search datapath
  logic [MAX_ELEMS-1:0]          j;
  logic [MAX_ELEMS-1:0]          j_inc;
  logic [MAX_ELEMS-1:0]          last_j;
  logic [MAX_ELEMS-1:0]          mask;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       rdata_ext;
  logic [CNT_W-1:0]              cnt;
  logic [IDX_W-1:0]              flip_idx;
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic                          match;
  logic                          upd_large;
  logic                          upd_small;

  // stored answer
  logic [MAX_ELEMS-1:0]          lmask;
  logic [MAX_ELEMS-1:0]          smask;
  logic [CNT_W-1:0]              lcnt;
  logic [CNT_W-1:0]              scnt;
  logic                          any_found;

  // answer scan
  logic                          which;
  logic [IDX_W-1:0]              p;
  logic [MAX_ELEMS-1:0]          mask_sel;
  logic [MAX_ELEMS-1:0]          mask_above;

  ssmm_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl),
    .busy (busy)
  );

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // gray code step: the bit that flips is the lowest set bit of j + 1
  assign j_inc     = j + 1'b1;
  assign last_j    = {MAX_ELEMS{1'b1}} >> (CNT_W'(MAX_ELEMS) - count);
  assign rdata_ext = SUM_W'(rdata);
  assign match     = (sum == SUM_W'(target_sum));

  // equal count: the earlier subset in post-order has the larger bit-reversed mask
  assign upd_large = match && (!any_found || cnt > lcnt ||
                     (cnt == lcnt && bitrev(mask) > bitrev(lmask)));
  assign upd_small = match && (!any_found || cnt < scnt ||
                     (cnt == scnt && bitrev(mask) > bitrev(smask)));

  assign mask_sel   = which ? smask : lmask;
  assign mask_above = (mask_sel >> p) >> 1;

  always_comb begin
    cond.wait_go     = !(accept && last_element);
    cond.search_done = (j == last_j);
    cond.mask_empty  = (mask_sel == '0);
    cond.scan_more   = ((CNT_W'(p) + 1'b1) != count);
    cond.first_set   = !which;
  end

  always_ff @(posedge clk) begin
    if (accept && count < CNT_W'(MAX_ELEMS)) begin
      elem_mem[count[IDX_W-1:0]] <= element_value;
    end
    if (ctrl.advance) begin
      rdata <= elem_mem[ctz(j_inc)];
    end else if (ctrl.rd_elem) begin
      rdata <= elem_mem[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.finish) begin
      count <= '0;
    end else if (accept && count < CNT_W'(MAX_ELEMS)) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target_sum <= cfg_data;
    end
  end

  // subset walk
  always_ff @(posedge clk) begin
    if (ctrl.clr_search) begin
      j    <= '0;
      mask <= '0;
      sum  <= '0;
      cnt  <= '0;
    end
    if (ctrl.advance) begin
      j        <= j_inc;
      flip_idx <= ctz(j_inc);
    end
    if (ctrl.accum) begin
      mask[flip_idx] <= !mask[flip_idx];
      if (mask[flip_idx]) begin
        sum <= sum - rdata_ext;
        cnt <= cnt - 1'b1;
      end else begin
        sum <= sum + rdata_ext;
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lmask     <= '0;
      smask     <= '0;
      lcnt      <= '0;
      scnt      <= '0;
      any_found <= 1'b0;
    end else if (ctrl.clr_search) begin
      lmask     <= '0;
      smask     <= '0;
      lcnt      <= '0;
      scnt      <= '0;
      any_found <= 1'b0;
    end else if (ctrl.exam) begin
      if (upd_large) begin
        lmask <= mask;
        lcnt  <= cnt;
      end
      if (upd_small) begin
        smask <= mask;
        scnt  <= cnt;
      end
      if (match) begin
        any_found <= 1'b1;
      end
    end
  end

  // answer scan pointer and list select
  always_ff @(posedge clk) begin
    if (rst) begin
      which <= 1'b0;
      p     <= '0;
    end else begin
      if (ctrl.clr_search) begin
        which <= 1'b0;
      end else if (ctrl.next_set) begin
        which <= 1'b1;
      end
      if (ctrl.emit_begin) begin
        p <= '0;
      end else if (ctrl.emit_member) begin
        p <= p + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ctrl.emit_member && mask_sel[p]) || ctrl.emit_marker;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_member) begin
      which_subset <= which;
      member_value <= rdata;
      is_member    <= 1'b1;
      found        <= any_found;
      last_result  <= which && (mask_above == '0);
    end else if (ctrl.emit_marker) begin
      which_subset <= which;
      member_value <= '0;
      is_member    <= 1'b0;
      found        <= any_found;
      last_result  <= which;
    end
  end

  // results only come out during a run
  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy)
    else $error("result outside a run");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_member) |-> found)
    else $error("member reported without a match");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_member) |-> (member_value == '0))
    else $error("marker carries a value");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> which_subset)
    else $error("run ended on the largest list");

  assert property (@(posedge clk) disable iff (rst)
    (accept && last_element) |=> busy)
    else $error("search did not start");

endmodule

### src/ssmm_useq.sv
module ssmm_useq import ssmm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  ucond_t cond,
  output uword_t ctrl,
  output logic   busy
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign ctrl = ucode(upc);
  assign busy = (upc != U_IDLE);

  always_comb begin
    unique case (ctrl.cond_sel)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_WAIT:   take = cond.wait_go;
      C_DONE:   take = cond.search_done;
      C_EMPTY:  take = cond.mask_empty;
      C_MORE:   take = cond.scan_more;
      C_FIRST:  take = cond.first_set;
      default:  take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### bench/tb_subset_sum_min_max_cardinality.sv
`timescale 1ns / 1ps
module tb_subset_sum_min_max_cardinality;
  import ssmm_pkg::*;

  // longest correct silence is one full 16-element search
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 30;
  localparam int TARGET_MAX     = 1048575;
  localparam int TARGET_MIN     = -1048576;
  localparam int PRINT_CAP      = 40;

  // one answer entry as it leaves the block
  typedef struct {
    logic                          which;
    logic signed [VALUE_WIDTH-1:0] member;
    logic                          is_member;
    logic                          found;
    logic                          last_res;
  } answer_t;

  // holds the loaded set and the target, works out the answer run of every
  // search and checks what comes out against it
  class subset_answer_check;
    logic signed [VALUE_WIDTH-1:0] elems[MAX_ELEMS];
    int      n_loaded;
    int      target_val;
    answer_t answer_q[$];
    int      errors;
    int      checked;
    int      searches;

    function new();
      n_loaded   = 0;
      target_val = 0;
      errors     = 0;
      checked    = 0;
      searches   = 0;
    endfunction

    function void set_target(int t);
      target_val = t;
    endfunction

    // depth-first order: a comes ahead of b when the lowest differing
    // index belongs to a (so the empty set is always met last)
    function bit comes_first(int a, int b);
      int d;
      d = a ^ b;
      return (a & d & -d) != 0;
    endfunction

    // members in index order, or one marker when the mask is empty
    function void push_list(logic which, int mask, bit hit);
      answer_t a;
      bit      any;
      any = 1'b0;
      for (int i = 0; i < n_loaded; i++) begin
        if (mask[i]) begin
          a.which     = which;
          a.member    = elems[i];
          a.is_member = 1'b1;
          a.found     = hit;
          a.last_res  = 1'b0;
          answer_q.push_back(a);
          any = 1'b1;
        end
      end
      if (!any) begin
        a.which     = which;
        a.member    = '0;
        a.is_member = 1'b0;
        a.found     = hit;
        a.last_res  = 1'b0;
        answer_q.push_back(a);
      end
    endfunction

    function void take_element(logic signed [VALUE_WIDTH-1:0] v, logic last_flag);
      int sum;
      int cnt;
      int big_n;
      int small_n;
      int big_m;
      int small_m;
      bit hit;
      // a full store drops the element, the last flag still counts
      if (n_loaded < MAX_ELEMS) begin
        elems[n_loaded] = v;
        n_loaded++;
      end
      if (!last_flag) return;
      hit     = 1'b0;
      big_n   = 0;
      small_n = 0;
      big_m   = 0;
      small_m = 0;
      // every subset; ties go to the one met first in depth-first order
      for (int m = 0; m < (1 << n_loaded); m++) begin
        sum = 0;
        cnt = 0;
        for (int i = 0; i < n_loaded; i++) begin
          if (m[i]) begin
            sum += int'(elems[i]);
            cnt++;
          end
        end
        if (sum == target_val) begin
          if (!hit || cnt > big_n || (cnt == big_n && comes_first(m, big_m))) begin
            big_n = cnt;
            big_m = m;
          end
          if (!hit || cnt < small_n || (cnt == small_n && comes_first(m, small_m))) begin
            small_n = cnt;
            small_m = m;
          end
          hit = 1'b1;
        end
      end
      push_list(1'b0, big_m, hit);
      push_list(1'b1, small_m, hit);
      answer_q[answer_q.size()-1].last_res = 1'b1;
      n_loaded = 0;
      searches++;
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      checked++;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: unexpected result which %0d member %0d is_member %0d found %0d last %0d",
                   $time, got.which, got.member, got.is_member, got.found, got.last_res);
        return;
      end
      want = answer_q.pop_front();
      if (got.which !== want.which || got.member !== want.member ||
          got.is_member !== want.is_member || got.found !== want.found ||
          got.last_res !== want.last_res) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: expected which %0d member %0d is_member %0d found %0d last %0d, %s %0d %0d %0d %0d %0d",
                   $time, want.which, want.member, want.is_member, want.found,
                   want.last_res, "got", got.which, got.member, got.is_member,
                   got.found, got.last_res);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] element_value;
  logic                          last_element;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic signed [TARGET_W-1:0]    cfg_data;
  logic                          result_valid;
  logic                          which_subset;
  logic signed [VALUE_WIDTH-1:0] member_value;
  logic                          is_member;
  logic                          found;
  logic                          last_result;

  subset_answer_check            sb;
  answer_t                       seen;
  logic signed [VALUE_WIDTH-1:0] set_vals[$];
  int                            items_sent = 0;
  int                            idle_cycles = 0;

  subset_sum_min_max_cardinality u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .element_value(element_value),
    .last_element (last_element),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .which_subset (which_subset),
    .member_value (member_value),
    .is_member    (is_member),
    .found        (found),
    .last_result  (last_result)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // small values give many matching subsets, full range hits every bit
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input int mode);
    int r;
    case (mode)
      0: return VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
      1: return VALUE_WIDTH'(int'($urandom_range(0, 32)) - 16);
      2: return VALUE_WIDTH'($urandom);
      default: begin
        r = $urandom_range(0, 7);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r == 2) return '1;
        return VALUE_WIDTH'(int'($urandom_range(0, 6)) - 3);
      end
    endcase
  endfunction

  // mostly the sum of a random part of the pending set, so matches happen
  function automatic int pick_target();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      s = 0;
      foreach (set_vals[i]) begin
        if ($urandom_range(0, 1) != 0) s += int'(set_vals[i]);
      end
      return s;
    end
    if (r < 75) return 0;
    if (r < 83) return ($urandom_range(0, 1) != 0) ? TARGET_MAX : TARGET_MIN;
    if (r < 91) return int'($urandom_range(0, 40)) - 20;
    return int'($urandom_range(0, 2097151)) + TARGET_MIN;
  endfunction

  // one input request; start stays high on return so a back-to-back
  // request can follow without a dip
  task automatic send_element(input logic signed [VALUE_WIDTH-1:0] v, input logic lst,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    element_value <= v;
    last_element  <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_element(v, lst);
    items_sent++;
  endtask

  // target write only once the answer is out and the block has settled
  task automatic write_target(input int t);
    start <= 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t[TARGET_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_target(t);
  endtask

  // pending set goes in, last flag on its final element
  task automatic load_set(input bit gaps_on);
    int g;
    for (int i = 0; i < set_vals.size(); i++) begin
      g = gaps_on ? pick_gap() : 0;
      send_element(set_vals[i], i == set_vals.size() - 1, g);
    end
  endtask

  task automatic one_element_set(input logic signed [VALUE_WIDTH-1:0] v, input int t);
    set_vals.delete();
    set_vals.push_back(v);
    write_target(t);
    load_set(1'b0);
  endtask

  // result monitor: strobe lasts one cycle, no back-pressure
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      seen.which     = which_subset;
      seen.member    = member_value;
      seen.is_member = is_member;
      seen.found     = found;
      seen.last_res  = last_result;
      sb.check_result(seen);
    end
  end

  // watchdog on cycles with no request, write or result
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("subset_sum_min_max_cardinality: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int r;
    int mode;
    int directed_items;
    sb = new();
    rst           <= 1'b1;
    start         <= 1'b0;
    element_value <= '0;
    last_element  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single extreme elements, each matched by itself
    one_element_set(16'sh7fff, 32767);
    one_element_set(16'sh8000, -32768);
    // zero element with zero target: largest is the element, smallest is empty
    one_element_set(16'sh0000, 0);
    // only the empty set matches: both lists are markers with found high
    one_element_set(16'sh0005, 0);
    // target extremes, unreachable: markers with found low
    one_element_set(16'sh0007, TARGET_MAX);
    one_element_set(-16'sh0007, TARGET_MIN);

    // full store: two past capacity, the extra one and the last are dropped,
    // the last flag still starts the search over all sixteen
    set_vals.delete();
    set_vals.push_back(16'sh7fff);
    set_vals.push_back(16'sh8000);
    for (int i = 2; i < MAX_ELEMS + 2; i++)
      set_vals.push_back(VALUE_WIDTH'(int'($urandom_range(0, 6)) - 3));
    write_target(2);
    load_set(1'b1);
    directed_items = items_sent;

    // random sets, mostly small since a search walks all 2^n subsets
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) n = $urandom_range(1, 8);
      else if (r < 97) n = $urandom_range(9, 11);
      else n = $urandom_range(12, 13);
      mode = $urandom_range(0, 3);
      set_vals.delete();
      for (int i = 0; i < n; i++) set_vals.push_back(pick_value(mode));
      // keeping the old target lets start wait high through a search
      if ($urandom_range(0, 9) < 7) write_target(pick_target());
      load_set($urandom_range(0, 3) != 0);
    end

    // drain
    start <= 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("searched %0d sets from %0d element requests, %0d results compared",
             sb.searches, items_sent, sb.checked);
    $display("targets ran from %0d to %0d, store overflow included", TARGET_MIN, TARGET_MAX);
    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("subset_sum_min_max_cardinality: match");
    end else begin
      $display("subset_sum_min_max_cardinality: mismatch");
    end
    $finish;
  end

endmodule
